FILE: rtl/core/gcwd_pkg.sv
// Package: shared types and constants of the command word decoder.
`default_nettype none
package gcwd_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] word;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [23:0] color;
    logic [31:0] data;
    logic        last;
  } out_word_t;

  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_CTRL   = 2'd1;
  localparam logic [1:0] MODE_DREAD  = 2'd2;
  localparam logic [1:0] MODE_STREAD = 2'd3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_HEADER = 2'd2;
  localparam logic [1:0] KIND_PIXEL  = 2'd3;

  localparam logic [7:0] OP_FLAT_QUAD = 8'h28;
  localparam logic [7:0] OP_TEX_QUAD  = 8'h2C;
  localparam logic [7:0] OP_SH_TRI    = 8'h30;
  localparam logic [7:0] OP_SH_QUAD   = 8'h38;
  localparam logic [7:0] OP_IMG_UP    = 8'hA0;
  localparam logic [7:0] OP_IMG_DN    = 8'hC0;
  localparam logic [7:0] OP_DRAW_MODE = 8'hE1;
  localparam logic [7:0] OP_DRAW_OFS  = 8'hE5;
  localparam logic [7:0] OP_MASK      = 8'hE6;

  localparam logic [7:0] CT_RESET     = 8'h00;
  localparam logic [7:0] CT_DROP      = 8'h01;
  localparam logic [7:0] CT_ACK_IRQ   = 8'h02;
  localparam logic [7:0] CT_DISP_EN   = 8'h03;
  localparam logic [7:0] CT_DMA_DIR   = 8'h04;
  localparam logic [7:0] CT_DISP_MODE = 8'h08;

  localparam logic [31:0] STATUS_RESET = 32'h0080_0000;

  // Job kinds handed from front to back.
  typedef enum logic [2:0] {
    JOB_READ,
    JOB_PIXEL,
    JOB_HEADER,
    JOB_FLAT_QUAD,
    JOB_TEX_QUAD,
    JOB_SH_TRI,
    JOB_SH_QUAD
  } job_t;

  function automatic logic [3:0] packet_len(input logic [7:0] op);
    logic [3:0] len;
    unique case (op)
      OP_FLAT_QUAD: len = 4'd5;
      OP_TEX_QUAD:  len = 4'd9;
      OP_SH_TRI:    len = 4'd6;
      OP_SH_QUAD:   len = 4'd8;
      OP_IMG_UP:    len = 4'd3;
      OP_IMG_DN:    len = 4'd3;
      default:      len = 4'd1;
    endcase
    return len;
  endfunction

  function automatic logic [15:0] sext11(input logic [10:0] v);
    return {{5{v[10]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gcwd_front.sv
// Front end: packet assembly, status/control, job issue into the queue.
`default_nettype none
module gcwd_front #(
  parameter int MAX_PACKET_WORDS = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gcwd_pkg::in_word_t in_w,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             q_ready,
  output logic                  q_push,
  output gcwd_pkg::job_t        q_job,
  output logic [32*MAX_PACKET_WORDS-1:0] q_words,
  output logic [15:0]           q_ofs_x,
  output logic [15:0]           q_ofs_y
);
  import gcwd_pkg::*;

  logic [31:0] status_word;
  logic [31:0] cmd [MAX_PACKET_WORDS];
  logic [31:0] words_left;
  logic [7:0]  opcode;
  logic        image_loading;
  logic [15:0] offset_x, offset_y;
  logic [31:0] px_cnt;   // pixel pairs pending from the multiply stage
  logic        px_pend;

  logic        acc;
  logic [7:0]  op_eff;
  logic [31:0] left_eff;
  logic [3:0]  len;
  logic [31:0] idx;
  logic [31:0] cmd_next [MAX_PACKET_WORDS];
  logic        done;

  // The image size product is not needed until the next word arrives; a
  // header cycle computes it (registered).
  assign in_ready = q_ready;
  assign acc      = in_valid & in_ready;

  always_comb begin
    op_eff   = (words_left == 32'd0) ? in_w.word[31:24] : opcode;
    left_eff = (words_left == 32'd0) ? {28'd0, packet_len(in_w.word[31:24])} : words_left;
    len      = packet_len(op_eff);
    idx      = (left_eff <= {28'd0, len}) ? ({28'd0, len} - left_eff) : 32'd0;
    done     = (left_eff == 32'd1);
    for (int i = 0; i < MAX_PACKET_WORDS; i++) begin
      cmd_next[i] = cmd[i];
      if (idx == i) cmd_next[i] = in_w.word;
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = JOB_READ;
    if (acc) begin
      unique case (in_w.mode)
        MODE_CMD: begin
          if (image_loading) begin
            q_push = 1'b1;
            q_job  = JOB_PIXEL;
          end else if (done) begin
            priority case (op_eff)
              OP_FLAT_QUAD: begin q_push = 1'b1; q_job = JOB_FLAT_QUAD; end
              OP_TEX_QUAD:  begin q_push = 1'b1; q_job = JOB_TEX_QUAD; end
              OP_SH_TRI:    begin q_push = 1'b1; q_job = JOB_SH_TRI; end
              OP_SH_QUAD:   begin q_push = 1'b1; q_job = JOB_SH_QUAD; end
              OP_IMG_UP:    begin q_push = 1'b1; q_job = JOB_HEADER; end
              default:      q_push = 1'b0;
            endcase
          end
        end
        MODE_CTRL:   q_push = 1'b0;
        MODE_DREAD:  begin q_push = 1'b1; q_job = JOB_READ; end
        MODE_STREAD: begin q_push = 1'b1; q_job = JOB_READ; end
        default:     q_push = 1'b0;
      endcase
    end
  end

  // Payload: words snapshot; read data rides in word 0.
  always_comb begin
    for (int i = 0; i < MAX_PACKET_WORDS; i++) q_words[32*i +: 32] = cmd_next[i];
    if (in_w.mode == MODE_STREAD)
      q_words[31:0] = (status_word & ~(32'd1 << 19)) | (32'd7 << 26);
    else if (in_w.mode == MODE_DREAD)
      q_words[31:0] = 32'd0;
    else if (image_loading)
      q_words[31:0] = in_w.word;
    q_ofs_x = offset_x;
    q_ofs_y = offset_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_word   <= STATUS_RESET;
      words_left    <= '0;
      opcode        <= '0;
      image_loading <= 1'b0;
      offset_x      <= '0;
      offset_y      <= '0;
      px_pend       <= 1'b0;
      px_cnt        <= '0;
    end else begin
      if (px_pend) begin
        // pixel count is loaded in the cycle after the header
        px_pend <= 1'b0;
        if (!(acc && in_w.mode == MODE_CTRL &&
              (in_w.word[31:24] == CT_RESET || in_w.word[31:24] == CT_DROP))) begin
          words_left    <= px_cnt;
          image_loading <= (px_cnt != 32'd0);
        end
      end
      if (acc) begin
        unique case (in_w.mode)
          MODE_CMD: begin
            if (image_loading) begin
              words_left <= words_left - 32'd1;
              if (words_left == 32'd1) image_loading <= 1'b0;
            end else begin
              opcode <= op_eff;
              for (int i = 0; i < MAX_PACKET_WORDS; i++) cmd[i] <= cmd_next[i];
              words_left <= left_eff - 32'd1;
              if (done) begin
                priority case (op_eff)
                  OP_IMG_UP: begin
                    px_cnt  <= 32'((({16'd0, cmd_next[2][15:0]} *
                                     {16'd0, cmd_next[2][31:16]}) + 33'd1) >> 1);
                    px_pend <= 1'b1;
                  end
                  OP_DRAW_MODE: begin
                    status_word[9:0] <= cmd_next[0][9:0];
                    status_word[15]  <= cmd_next[0][11];
                  end
                  OP_DRAW_OFS: begin
                    offset_x <= sext11(cmd_next[0][10:0]);
                    offset_y <= sext11(cmd_next[0][21:11]);
                  end
                  OP_MASK: status_word[12:11] <= cmd_next[0][1:0];
                  default: ;
                endcase
              end
            end
          end
          MODE_CTRL: begin
            unique case (in_w.word[31:24])
              CT_RESET: begin
                words_left <= '0; image_loading <= 1'b0; opcode <= '0;
                status_word <= STATUS_RESET; offset_x <= '0; offset_y <= '0;
              end
              CT_DROP: begin
                words_left <= '0; image_loading <= 1'b0; opcode <= '0;
              end
              CT_ACK_IRQ:   status_word[24] <= 1'b0;
              CT_DISP_EN:   status_word[23] <= in_w.word[0];
              CT_DMA_DIR:   status_word[30:29] <= in_w.word[1:0];
              CT_DISP_MODE: begin
                status_word[22:17] <= in_w.word[5:0];
                status_word[16]    <= in_w.word[6];
                status_word[14]    <= in_w.word[7];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gcwd_queue.sv
// Short job queue between front and back ends.
`default_nettype none
module gcwd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              not_full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] rd_ptr, wr_ptr;
  logic [AW:0]   count;

  assign not_full  = (count != AW'(0) + (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push & not_full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0; wr_ptr <= '0; count <= '0;
    end else begin
      if (push & not_full)
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      if (pop & not_empty)
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push & not_full) - (AW+1)'(pop & not_empty);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gcwd_back.sv
// Back end: expands one job into its output words.
`default_nettype none
module gcwd_back #(
  parameter int MAX_PACKET_WORDS = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             j_valid,
  input  wire gcwd_pkg::job_t   j_job,
  input  wire logic [32*MAX_PACKET_WORDS-1:0] j_words,
  input  wire logic [15:0]      j_ofs_x,
  input  wire logic [15:0]      j_ofs_y,
  output logic                  j_pop,
  output gcwd_pkg::out_word_t   out_w,
  output logic                  out_valid,
  input  wire logic             out_ready
);
  import gcwd_pkg::*;

  logic [2:0] step;
  logic [2:0] n_steps;
  logic [3:0] pidx, cidx;
  logic [31:0] pw, cwd;
  out_word_t  res;
  logic       fire, ld;

  function automatic logic [31:0] cw(input logic [32*MAX_PACKET_WORDS-1:0] w,
                                     input logic [3:0] i);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < MAX_PACKET_WORDS; k++)
      if (i == k) r = w[32*k +: 32];
    return r;
  endfunction

  always_comb begin
    pidx = 4'd1; cidx = 4'd0; n_steps = 3'd1;
    unique case (j_job)
      JOB_FLAT_QUAD: begin
        n_steps = 3'd6;
        pidx = (step < 3'd3) ? 4'(step) + 4'd1 : 4'(step) - 4'd1;
      end
      JOB_TEX_QUAD: begin
        n_steps = 3'd6;
        pidx = (step < 3'd3) ? {step[2:0], 1'b1} : {step - 3'd2, 1'b1};
      end
      JOB_SH_TRI, JOB_SH_QUAD: begin
        n_steps = (j_job == JOB_SH_TRI) ? 3'd3 : 3'd6;
        pidx = (step < 3'd3) ? {step[2:0], 1'b1} : {step - 3'd2, 1'b1};
        cidx = pidx - 4'd1;
      end
      default: ;
    endcase
    pw  = cw(j_words, pidx);
    cwd = cw(j_words, cidx);
    res = '0;
    res.last = (step == n_steps - 3'd1);
    unique case (j_job)
      JOB_READ:   begin res.kind = KIND_READ;  res.data = j_words[31:0]; end
      JOB_PIXEL:  begin res.kind = KIND_PIXEL; res.data = j_words[31:0]; end
      JOB_HEADER: begin
        res.kind = KIND_HEADER;
        res.pos_x = j_words[47:32]; res.pos_y = j_words[63:48];
        res.data = j_words[95:64];
      end
      default: begin
        res.kind  = KIND_VERTEX;
        res.pos_x = pw[15:0] + j_ofs_x;
        res.pos_y = pw[31:16] + j_ofs_y;
        res.color = cwd[23:0];
      end
    endcase
  end

  assign ld    = ~out_valid | out_ready;
  assign fire  = j_valid & ld;
  assign j_pop = fire & res.last;

  always_ff @(posedge clk) begin
    if (fire) out_w <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; step <= '0;
    end else begin
      if (ld) out_valid <= j_valid;
      if (fire) step <= res.last ? 3'd0 : step + 3'd1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gpu_command_word_decoder.sv
// Top level: command word decoder, front end, job queue and back end.
`default_nettype none
// A bus access (command write, control write, data or status read) is taken
// each cycle while the job queue has room. Control writes and packet words
// that end nothing produce no output. A finished draw packet issues one job
// that the back end expands into 3 or 6 vertex words at one per cycle while
// the output is not stalled; reads, image headers and pixel-pair words give
// one word each. Each job passes through the job queue (four entries deep)
// and the back end's output register. The input stalls while a vertex burst
// or a stalled output keeps the queue full. The image size product is
// registered on the edge that takes the header and loaded into the word count
// in the following cycle; the input is held off in that cycle.
module gpu_command_word_decoder #(
  parameter int MAX_PACKET_WORDS = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gcwd_pkg::in_word_t  in_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output gcwd_pkg::out_word_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import gcwd_pkg::*;

  localparam int JW = 3 + 32*MAX_PACKET_WORDS + 32;

  logic          q_push, q_nf, q_ne, q_pop, f_ready, hold;
  job_t          f_job;
  logic [32*MAX_PACKET_WORDS-1:0] f_words;
  logic [15:0]   f_ox, f_oy;
  logic [JW-1:0] q_out;
  logic [2:0]    b_job_bits;
  logic          hdr_seen;

  // hold in the cycle after an image header so the pixel count settles
  always_ff @(posedge clk) begin
    if (rst) hdr_seen <= 1'b0;
    else     hdr_seen <= q_push & q_nf & (f_job == JOB_HEADER);
  end
  assign hold     = hdr_seen;
  assign in_ready = f_ready & ~hold;

  gcwd_front #(.MAX_PACKET_WORDS(MAX_PACKET_WORDS)) u_front (
    .clk, .rst, .in_w(in_data), .in_valid(in_valid & ~hold), .in_ready(f_ready),
    .q_ready(q_nf), .q_push, .q_job(f_job), .q_words(f_words),
    .q_ofs_x(f_ox), .q_ofs_y(f_oy)
  );

  gcwd_queue #(.W(JW), .DEPTH(4)) u_queue (
    .clk, .rst, .push(q_push), .push_data({f_job, f_words, f_ox, f_oy}),
    .not_full(q_nf), .pop(q_pop), .pop_data(q_out), .not_empty(q_ne)
  );

  assign b_job_bits = q_out[JW-1 -: 3];

  gcwd_back #(.MAX_PACKET_WORDS(MAX_PACKET_WORDS)) u_back (
    .clk, .rst, .j_valid(q_ne), .j_job(job_t'(b_job_bits)),
    .j_words(q_out[JW-4 -: 32*MAX_PACKET_WORDS]),
    .j_ofs_x(q_out[31:16]), .j_ofs_y(q_out[15:0]), .j_pop(q_pop),
    .out_w(out_data), .out_valid, .out_ready
  );
endmodule
`default_nettype wire

FILE: rtl/core/gcwd_checker.sv
// Port-level checker for the command word decoder, bound to the top level.
`default_nettype none
module gcwd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire gcwd_pkg::in_word_t  in_data,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire gcwd_pkg::out_word_t out_data,
  input wire logic                out_valid,
  input wire logic                out_ready
);
  import gcwd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_READ |-> out_data.last)
    else $error("read result without last");

  a_vertex_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_VERTEX |-> out_data.data == 32'd0)
    else $error("vertex carries data");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind gpu_command_word_decoder gcwd_checker u_checker (
  .clk, .rst, .in_data, .in_valid, .in_ready, .out_data, .out_valid, .out_ready
);
`default_nettype wire

FILE: sim/tb_gpu_command_word_decoder.sv
// Testbench: drives bus accesses into the command word decoder and checks every output word.
`default_nettype none
module tb_gpu_command_word_decoder;
  import gcwd_pkg::*;

  logic clk;
  logic rst;
  in_word_t in_data;
  logic in_valid;
  logic in_ready;
  out_word_t out_data;
  logic out_valid;
  logic out_ready;

  gpu_command_word_decoder uut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  // Shadow of the decoder state.
  logic [31:0] sh_status;
  logic [31:0] sh_words [0:8];
  logic [31:0] sh_left;
  logic [7:0]  sh_op;
  logic        sh_img;
  logic [15:0] sh_ofs_x;
  logic [15:0] sh_ofs_y;

  out_word_t pending_words[$];
  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] pkt_words(input logic [7:0] op);
    case (op)
      OP_FLAT_QUAD: return 5;
      OP_TEX_QUAD:  return 9;
      OP_SH_TRI:    return 6;
      OP_SH_QUAD:   return 8;
      OP_IMG_UP:    return 3;
      OP_IMG_DN:    return 3;
      default:      return 1;
    endcase
  endfunction

  function automatic logic [15:0] sign_ext11(input logic [31:0] v);
    return {{5{v[10]}}, v[10:0]};
  endfunction

  function automatic out_word_t mk(input logic [1:0] k, input logic [15:0] x,
                                   input logic [15:0] y, input logic [23:0] c,
                                   input logic [31:0] d, input logic l);
    out_word_t r;
    r.kind = k; r.pos_x = x; r.pos_y = y; r.color = c; r.data = d; r.last = l;
    return r;
  endfunction

  task automatic expect_word(input out_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_vertex(input logic [31:0] pos, input logic [31:0] col,
                             input logic l);
    expect_word(mk(KIND_VERTEX, pos[15:0] + sh_ofs_x,
                   pos[31:16] + sh_ofs_y, col[23:0], 32'd0, l));
  endtask

  task automatic finish_packet();
    int pidx [6];
    logic [31:0] pixels;
    logic [31:0] sz;
    logic [31:0] c0;
    c0 = sh_words[0];
    pidx = '{1, 3, 5, 3, 5, 7};
    case (sh_op)
      OP_FLAT_QUAD: begin
        pidx = '{1, 2, 3, 2, 3, 4};
        for (int i = 0; i < 6; i++) push_vertex(sh_words[pidx[i]], c0, i == 5);
      end
      OP_TEX_QUAD:
        for (int i = 0; i < 6; i++) push_vertex(sh_words[pidx[i]], c0, i == 5);
      OP_SH_TRI:
        for (int i = 0; i < 3; i++)
          push_vertex(sh_words[pidx[i]], sh_words[pidx[i] - 1], i == 2);
      OP_SH_QUAD:
        for (int i = 0; i < 6; i++)
          push_vertex(sh_words[pidx[i]], sh_words[pidx[i] - 1], i == 5);
      OP_IMG_UP: begin
        sz = sh_words[2];
        pixels = sz[15:0] * sz[31:16];
        expect_word(mk(KIND_HEADER, sh_words[1][15:0], sh_words[1][31:16],
                       24'd0, sz, 1'b1));
        // 33 bits so a full 32-bit product plus one cannot wrap
        sh_left = ({1'b0, pixels} + 33'd1) >> 1;
        sh_img = (sh_left != 0);
      end
      OP_DRAW_MODE: begin
        sh_status[9:0] = c0[9:0];
        sh_status[15] = c0[11];
      end
      OP_DRAW_OFS: begin
        sh_ofs_x = sign_ext11(c0);
        sh_ofs_y = sign_ext11(c0 >> 11);
      end
      OP_MASK: sh_status[12:11] = c0[1:0];
      default: ;
    endcase
  endtask

  // Advance the shadow by one accepted bus access.
  task automatic predict_access(input in_word_t a);
    logic [31:0] len;
    logic [31:0] idx;
    logic [31:0] st;
    case (a.mode)
      MODE_CMD: begin
        if (sh_img) begin
          sh_left = sh_left - 1;
          if (sh_left == 0) sh_img = 1'b0;
          expect_word(mk(KIND_PIXEL, 16'd0, 16'd0, 24'd0, a.word, 1'b1));
        end else begin
          if (sh_left == 0) begin
            sh_op = a.word[31:24];
            sh_left = pkt_words(sh_op);
          end
          len = pkt_words(sh_op);
          idx = (sh_left <= len) ? len - sh_left : 0;
          if (idx < 9) sh_words[idx] = a.word;
          sh_left = sh_left - 1;
          if (sh_left == 0) finish_packet();
        end
      end
      MODE_CTRL: begin
        case (a.word[31:24])
          CT_RESET: begin
            sh_left = 0; sh_img = 1'b0; sh_op = 8'd0;
            sh_status = STATUS_RESET; sh_ofs_x = 16'd0; sh_ofs_y = 16'd0;
          end
          CT_DROP: begin
            sh_left = 0; sh_img = 1'b0; sh_op = 8'd0;
          end
          CT_ACK_IRQ: sh_status[24] = 1'b0;
          CT_DISP_EN: sh_status[23] = a.word[0];
          CT_DMA_DIR: sh_status[30:29] = a.word[1:0];
          CT_DISP_MODE: begin
            sh_status[22:17] = a.word[5:0];
            sh_status[16] = a.word[6];
            sh_status[14] = a.word[7];
          end
          default: ;
        endcase
      end
      MODE_DREAD:
        expect_word(mk(KIND_READ, 16'd0, 16'd0, 24'd0, 32'd0, 1'b1));
      default: begin
        st = sh_status;
        st[19] = 1'b0;
        st[28:26] = 3'b111;
        expect_word(mk(KIND_READ, 16'd0, 16'd0, 24'd0, st, 1'b1));
      end
    endcase
  endtask

  // valid stays up between back-to-back words; it drops only on idle cycles
  task automatic send_access(input logic [1:0] m, input logic [31:0] w);
    in_word_t a;
    a.mode = m;
    a.word = w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= a;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_access(a);
  endtask

  // Output checker and receiver stall.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected output word %p", out_data);
          fail_count++;
        end else begin
          exp_w = pending_words.pop_front();
          if (out_data.kind !== exp_w.kind) begin
            $error("kind exp %0h got %0h", exp_w.kind, out_data.kind); fail_count++;
          end
          if (out_data.pos_x !== exp_w.pos_x) begin
            $error("pos_x exp %0h got %0h", exp_w.pos_x, out_data.pos_x); fail_count++;
          end
          if (out_data.pos_y !== exp_w.pos_y) begin
            $error("pos_y exp %0h got %0h", exp_w.pos_y, out_data.pos_y); fail_count++;
          end
          if (out_data.color !== exp_w.color) begin
            $error("color exp %0h got %0h", exp_w.color, out_data.color); fail_count++;
          end
          if (out_data.data !== exp_w.data) begin
            $error("data exp %0h got %0h", exp_w.data, out_data.data); fail_count++;
          end
          if (out_data.last !== exp_w.last) begin
            $error("last exp %0h got %0h", exp_w.last, out_data.last); fail_count++;
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_pos();
    return $urandom();
  endfunction

  // Packet of the given opcode with random content.
  task automatic send_draw_packet(input logic [7:0] op);
    logic [31:0] n;
    n = pkt_words(op);
    send_access(MODE_CMD, {op, 24'($urandom())});
    for (int i = 1; i < n; i++) send_access(MODE_CMD, rnd_pos());
  endtask

  task automatic send_image(input logic [15:0] w, input logic [15:0] h);
    int n;
    send_access(MODE_CMD, {OP_IMG_UP, 24'($urandom())});
    send_access(MODE_CMD, $urandom());
    send_access(MODE_CMD, {h, w});
    n = (w * h + 1) / 2;
    for (int i = 0; i < n; i++) send_access(MODE_CMD, $urandom());
  endtask

  task automatic test_reads_and_control();
    send_access(MODE_STREAD, 32'hFFFF_FFFF);
    send_access(MODE_DREAD, 32'h0);
    send_access(MODE_CTRL, {CT_DISP_EN, 24'h0});
    send_access(MODE_CTRL, {CT_DMA_DIR, 24'h3});
    send_access(MODE_CTRL, {CT_DISP_MODE, 24'hFF});
    send_access(MODE_CTRL, {CT_ACK_IRQ, 24'h0});
    send_access(MODE_CTRL, {8'h07, 24'hFFFFFF});
    send_access(MODE_STREAD, 32'h0);
    send_access(MODE_CMD, {OP_DRAW_MODE, 24'hFFFFFF});
    send_access(MODE_CMD, {OP_MASK, 24'h3});
    send_access(MODE_STREAD, 32'h0);
    send_access(MODE_CTRL, {CT_RESET, 24'h0});
    send_access(MODE_STREAD, 32'h0);
  endtask

  task automatic test_draw_packets();
    send_access(MODE_CMD, {OP_DRAW_OFS, 24'h3FFFFF});  // both offsets minus one
    send_draw_packet(OP_FLAT_QUAD);
    send_access(MODE_CMD, {OP_DRAW_OFS, 24'h2003FF});  // x max positive, y min negative
    send_draw_packet(OP_TEX_QUAD);
    send_draw_packet(OP_SH_TRI);
    send_draw_packet(OP_SH_QUAD);
    send_draw_packet(OP_IMG_DN);
    send_access(MODE_CMD, 32'h0);
    send_access(MODE_CMD, 32'hFFFF_FFFF);  // unknown opcode
  endtask

  task automatic test_image_upload();
    send_image(16'd0, 16'd7);    // zero size: header only
    send_image(16'd3, 16'd3);    // odd pixel count
    send_draw_packet(OP_SH_TRI);
    // dropped mid-image and mid-packet
    send_access(MODE_CMD, {OP_IMG_UP, 24'h0});
    send_access(MODE_CMD, 32'h0);
    send_access(MODE_CMD, 32'h0004_0004);
    send_access(MODE_CMD, 32'h1234_5678);
    send_access(MODE_CTRL, {CT_DROP, 24'h0});
    send_access(MODE_CMD, {OP_SH_QUAD, 24'h0});
    send_access(MODE_CTRL, {CT_DROP, 24'h0});
  endtask

  task automatic test_random(input int count);
    int sel;
    logic [7:0] ops [5];
    ops = '{OP_FLAT_QUAD, OP_TEX_QUAD, OP_SH_TRI, OP_SH_QUAD, OP_IMG_DN};
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) send_draw_packet(ops[$urandom_range(4)]);
      else if (sel < 55) send_image(16'($urandom_range(4)), 16'($urandom_range(4)));
      else if (sel < 65) send_access(MODE_CMD, {OP_DRAW_OFS, 24'($urandom())});
      else if (sel < 70)
        send_access(MODE_CMD,
                    {($urandom_range(1) ? OP_DRAW_MODE : OP_MASK), 24'($urandom())});
      else if (sel < 80) send_access(MODE_CTRL, {8'($urandom_range(9)), 24'($urandom())});
      else if (sel < 83) send_access(MODE_CTRL, $urandom());
      else if (sel < 95) send_access(2'($urandom_range(2, 3)), $urandom());
      else send_access(MODE_CMD, $urandom());  // noise, may open any packet
    end
    // close any open packet or image so later phases start clean
    send_access(MODE_CTRL, {CT_DROP, 24'h0});
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    sh_status = STATUS_RESET;
    sh_left = 0; sh_op = 8'd0; sh_img = 1'b0;
    sh_ofs_x = 16'd0; sh_ofs_y = 16'd0;
    foreach (sh_words[i]) sh_words[i] = 32'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reads_and_control();
    test_draw_packets();
    test_image_upload();
    wait_drained();  // sender holds until all output has come
    test_random(10);
    send_idle_pct = 73;
    test_random(10);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    test_random(10);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    test_random(10);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(5);
    wait_drained();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: gpu_command_word_decoder.f
rtl/core/gcwd_pkg.sv
rtl/core/gcwd_front.sv
rtl/core/gcwd_queue.sv
rtl/core/gcwd_back.sv
rtl/core/gpu_command_word_decoder.sv
rtl/core/gcwd_checker.sv
sim/tb_gpu_command_word_decoder.sv
